[design/lgtr_pkg.sv]
// Package for the LDA Gibbs token resampler: payload structs, sizes and
// controller/datapath command and status types. No dependencies.
package lgtr_pkg;

   localparam int NumTopics = 16;
   localparam int VocabSize = 4096;
   localparam int NumDocs   = 1024;
   localparam int TopicW    = 4;
   localparam int DocW      = 10;
   localparam int WordW     = 12;
   localparam int DtAddrW   = DocW + TopicW;
   localparam int TwAddrW   = TopicW + WordW;
   localparam int ClrCount  = NumTopics * VocabSize;
   localparam int ClrW      = TwAddrW + 1;

   localparam logic [1:0] CsrAlpha = 2'd0;
   localparam logic [1:0] CsrBeta  = 2'd1;
   localparam logic [1:0] CsrBetaT = 2'd2;

   localparam logic [1:0] StatOk    = 2'd0;
   localparam logic [1:0] StatUnder = 2'd1;
   localparam logic [1:0] StatZero  = 2'd2;

   localparam logic OpLoad     = 1'b0;
   localparam logic OpResample = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [9:0]  doc_index;
      logic [11:0] word_index;
      logic [3:0]  old_topic;
      logic [15:0] random_fraction;
   } req_type;

   typedef struct packed {
      logic [3:0] new_topic;
      logic [1:0] status;
   } rsp_type;

   localparam logic [2:0] CmdNone   = 3'd0;
   localparam logic [2:0] CmdClear  = 3'd1;
   localparam logic [2:0] CmdRead   = 3'd2;
   localparam logic [2:0] CmdDec    = 3'd3;
   localparam logic [2:0] CmdInc    = 3'd4;
   localparam logic [2:0] CmdWeight = 3'd5;
   localparam logic [2:0] CmdDiv    = 3'd6;
   localparam logic [2:0] CmdScan   = 3'd7;

   typedef struct packed {
      logic [2:0]        op;
      logic [ClrW-1:0]   clr_addr;
      logic [TopicW-1:0] topic;
      logic              first;
   } cmd_type;

   typedef struct packed {
      logic              div_done;
      logic              sum_zero;
      logic              under;
      logic [TopicW-1:0] pick;
   } stat_type;

endpackage

[design/lgtr_datapath.sv]
// Datapath: count memories, weight multiplier, bit-serial divider, draw scan.
// Depends on lgtr_pkg; driven by lgtr_ctrl.
module lgtr_datapath (
   input  logic                clock,
   input  logic                reset,
   input  lgtr_pkg::cmd_type   cmd,
   input  lgtr_pkg::req_type   req_ff,
   input  logic [15:0]         alpha_ff,
   input  logic [15:0]         beta_ff,
   input  logic [31:0]         betat_ff,
   output lgtr_pkg::stat_type  stat
);

   logic [15:0] dt_mem [0:lgtr_pkg::NumDocs*lgtr_pkg::NumTopics-1];
   logic [15:0] tw_mem [0:lgtr_pkg::ClrCount-1];
   logic [31:0] tot_ff [0:lgtr_pkg::NumTopics-1];
   logic [15:0] dt_q_ff, tw_q_ff;
   logic [31:0] tot_q_ff;
   logic [lgtr_pkg::DtAddrW-1:0] dt_addr;
   logic [lgtr_pkg::TwAddrW-1:0] tw_addr;
   logic        under_ff;
   logic [48:0] prod_ff;
   logic [40:0] den_ff;
   logic [48:0] quo_ff;
   logic [40:0] rem_ff;
   logic [5:0]  cnt_ff;
   logic [48:0] w_ff [0:lgtr_pkg::NumTopics-1];
   logic [52:0] sum_ff;
   logic [52:0] thr_ff, cum_ff;
   logic [lgtr_pkg::TopicW-1:0] pick_ff;
   logic        found_ff;
   logic [24:0] n1, n2;
   logic [49:0] prod_full;
   logic [40:0] den_raw;
   logic [41:0] trial;
   logic [52:0] cum_nx;
   logic [68:0] thr_full;

   assign dt_addr = {req_ff.doc_index, cmd.topic};
   assign tw_addr = {cmd.topic, req_ff.word_index};
   assign n1 = {1'b0, tw_q_ff, 8'd0} + {9'd0, beta_ff};
   assign n2 = {1'b0, dt_q_ff, 8'd0} + {9'd0, alpha_ff};
   assign prod_full = n1 * n2;
   assign den_raw = {1'b0, tot_q_ff, 8'd0} + {9'd0, betat_ff};
   assign trial = {rem_ff, quo_ff[48]} - {1'b0, den_ff};
   assign cum_nx = cum_ff + {4'd0, w_ff[cmd.topic]};
   assign thr_full = sum_ff * {37'd0, req_ff.random_fraction};

   always_ff @(posedge clock) begin
      case (cmd.op)
         lgtr_pkg::CmdClear: begin
            tw_mem[cmd.clr_addr[lgtr_pkg::TwAddrW-1:0]] <= '0;
            if (cmd.clr_addr < lgtr_pkg::ClrW'(lgtr_pkg::NumDocs*lgtr_pkg::NumTopics))
               dt_mem[cmd.clr_addr[lgtr_pkg::DtAddrW-1:0]] <= '0;
            if (cmd.clr_addr < lgtr_pkg::ClrW'(lgtr_pkg::NumTopics))
               tot_ff[cmd.clr_addr[lgtr_pkg::TopicW-1:0]] <= '0;
         end
         lgtr_pkg::CmdRead: begin
            dt_q_ff  <= dt_mem[dt_addr];
            tw_q_ff  <= tw_mem[tw_addr];
            tot_q_ff <= tot_ff[cmd.topic];
         end
         lgtr_pkg::CmdDec: begin
            if (dt_q_ff != 16'd0) dt_mem[dt_addr] <= dt_q_ff - 16'd1;
            if (tw_q_ff != 16'd0) tw_mem[tw_addr] <= tw_q_ff - 16'd1;
            if (tot_q_ff != 32'd0) tot_ff[cmd.topic] <= tot_q_ff - 32'd1;
         end
         lgtr_pkg::CmdInc: begin
            if (dt_q_ff != 16'hFFFF) dt_mem[dt_addr] <= dt_q_ff + 16'd1;
            if (tw_q_ff != 16'hFFFF) tw_mem[tw_addr] <= tw_q_ff + 16'd1;
            if (tot_q_ff != 32'hFFFF_FFFF) tot_ff[cmd.topic] <= tot_q_ff + 32'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         under_ff <= 1'b0;
         cnt_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         case (cmd.op)
            lgtr_pkg::CmdDec:
               under_ff <= (dt_q_ff == 16'd0) || (tw_q_ff == 16'd0) || (tot_q_ff == 32'd0);
            lgtr_pkg::CmdWeight: begin
               prod_ff <= prod_full[48:0];
               den_ff  <= (den_raw == 41'd0) ? 41'd1 : den_raw;
               rem_ff  <= '0;
               cnt_ff  <= '0;
               if (cmd.first) sum_ff <= '0;
            end
            lgtr_pkg::CmdDiv: begin
               if (cnt_ff == 6'd0) quo_ff <= prod_ff;
               else if (cnt_ff == 6'd50) begin
                  w_ff[cmd.topic] <= quo_ff;
                  sum_ff <= sum_ff + {4'd0, quo_ff};
               end else if (!trial[41]) begin
                  rem_ff <= trial[40:0];
                  quo_ff <= {quo_ff[47:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[39:0], quo_ff[48]};
                  quo_ff <= {quo_ff[47:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
            end
            lgtr_pkg::CmdScan: begin
               if (cmd.first) begin
                  thr_ff   <= thr_full[68:16];
                  cum_ff   <= '0;
                  found_ff <= 1'b0;
                  pick_ff  <= '1;
               end else if (!found_ff) begin
                  cum_ff <= cum_nx;
                  if (thr_ff < cum_nx) begin
                     found_ff <= 1'b1;
                     pick_ff  <= cmd.topic;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign stat.div_done = (cnt_ff == 6'd50);
   assign stat.sum_zero = (sum_ff == 53'd0);
   assign stat.under    = under_ff;
   assign stat.pick     = pick_ff;

endmodule

[design/lgtr_ctrl.sv]
// Controller: clearing pass, token sequencing and result register.
// Depends on lgtr_pkg; commands lgtr_datapath.
module lgtr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lgtr_pkg::req_type   req,
   output lgtr_pkg::req_type   req_ff,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lgtr_pkg::rsp_type   rsp,
   output lgtr_pkg::cmd_type   cmd,
   input  lgtr_pkg::stat_type  stat
);

   localparam logic [3:0] SClear = 4'd0, SIdle = 4'd1, SRd1 = 4'd2, SDec = 4'd3,
                          SRdK = 4'd4, SWgt = 4'd5, SDiv = 4'd6, SScan0 = 4'd7,
                          SScan = 4'd8, SRd2 = 4'd9, SInc = 4'd10, SOut = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [lgtr_pkg::ClrW-1:0] clr_ff, clr_in;
   logic [lgtr_pkg::TopicW-1:0] k_ff, k_in, t_ff, t_in;
   logic [1:0] st_ff, st_in;
   logic rv_ff, rv_in;
   lgtr_pkg::req_type rq_ff, rq_in;
   logic last_k, in_range;

   assign last_k = (k_ff == lgtr_pkg::TopicW'(lgtr_pkg::NumTopics - 1));
   assign in_range = (32'(req.doc_index) < lgtr_pkg::NumDocs)
                  && (32'(req.word_index) < lgtr_pkg::VocabSize)
                  && (32'(req.old_topic) < lgtr_pkg::NumTopics);
   assign req_ready = (state_ff == SIdle) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp = '{new_topic: t_ff, status: st_ff};
   assign req_ff = rq_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      k_in = k_ff;
      t_in = t_ff;
      st_in = st_ff;
      rv_in = rv_ff && !rsp_ready;
      rq_in = rq_ff;
      cmd = '{op: lgtr_pkg::CmdNone, clr_addr: clr_ff, topic: k_ff, first: 1'b0};
      case (state_ff)
         SClear: begin
            cmd.op = lgtr_pkg::CmdClear;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == lgtr_pkg::ClrW'(lgtr_pkg::ClrCount - 1)) state_in = SIdle;
         end
         SIdle: begin
            if (req_valid && req_ready) begin
               rq_in = req;
               t_in = req.old_topic;
               st_in = lgtr_pkg::StatOk;
               if (!in_range) begin
                  rv_in = 1'b1;
               end else if (req.opcode == lgtr_pkg::OpLoad) begin
                  state_in = SRd2;
               end else begin
                  state_in = SRd1;
               end
            end
         end
         SRd1: begin
            cmd.op = lgtr_pkg::CmdRead;
            cmd.topic = t_ff;
            state_in = SDec;
         end
         SDec: begin
            cmd.op = lgtr_pkg::CmdDec;
            cmd.topic = t_ff;
            k_in = '0;
            state_in = SRdK;
         end
         SRdK: begin
            cmd.op = lgtr_pkg::CmdRead;
            state_in = SWgt;
         end
         SWgt: begin
            cmd.op = lgtr_pkg::CmdWeight;
            cmd.first = (k_ff == '0);
            state_in = SDiv;
         end
         SDiv: begin
            cmd.op = lgtr_pkg::CmdDiv;
            if (stat.div_done) begin
               k_in = k_ff + 1'b1;
               state_in = last_k ? SScan0 : SRdK;
            end
         end
         SScan0: begin
            if (stat.sum_zero) begin
               st_in = lgtr_pkg::StatZero;
               state_in = SRd2;
            end else begin
               cmd.op = lgtr_pkg::CmdScan;
               cmd.first = 1'b1;
               k_in = '0;
               state_in = SScan;
            end
         end
         SScan: begin
            cmd.op = lgtr_pkg::CmdScan;
            k_in = k_ff + 1'b1;
            if (last_k) state_in = SOut;
         end
         SOut: begin
            t_in = stat.pick;
            st_in = stat.under ? lgtr_pkg::StatUnder : lgtr_pkg::StatOk;
            state_in = SRd2;
         end
         SRd2: begin
            cmd.op = lgtr_pkg::CmdRead;
            cmd.topic = t_ff;
            state_in = SInc;
         end
         SInc: begin
            cmd.op = lgtr_pkg::CmdInc;
            cmd.topic = t_ff;
            rv_in = 1'b1;
            state_in = SIdle;
         end
         default: state_in = SIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SClear;
         clr_ff <= '0;
         rv_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
         k_ff <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
      st_ff <= st_in;
      rq_ff <= rq_in;
   end

endmodule

[design/lda_gibbs_token_resampler_core.sv]
// LDA collapsed Gibbs token resampler, top level: configuration registers,
// controller and datapath. Depends on lgtr_pkg, lgtr_ctrl, lgtr_datapath.
//
// After reset a clearing pass over 65536 addresses zeroes the count stores;
// no request is taken until it ends. The run time of a resample is set by
// the bit-serial divider (one quotient bit a cycle over a 49-bit weight),
// run once per topic. One request is in flight at a time; a new one is
// taken once the result has been taken. Out-of-range requests are answered
// straight from the idle state, without touching the count stores.
module lda_gibbs_token_resampler_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lgtr_pkg::req_type  req,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lgtr_pkg::rsp_type  rsp,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   logic [15:0] alpha_ff, beta_ff;
   logic [31:0] betat_ff;
   lgtr_pkg::cmd_type  cmd;
   lgtr_pkg::stat_type stat;
   lgtr_pkg::req_type  req_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= 16'd26;
         beta_ff  <= 16'd13;
         betat_ff <= 32'd53248;
      end else if (csr_valid) begin
         case (csr_index)
            lgtr_pkg::CsrAlpha: alpha_ff <= csr_data[15:0];
            lgtr_pkg::CsrBeta:  beta_ff  <= csr_data[15:0];
            lgtr_pkg::CsrBetaT: betat_ff <= csr_data;
            default: ;
         endcase
      end
   end

   lgtr_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req, .req_ff,
      .rsp_valid, .rsp_ready, .rsp, .cmd, .stat
   );

   lgtr_datapath u_dp (
      .clock, .reset, .cmd, .req_ff, .alpha_ff, .beta_ff, .betat_ff, .stat
   );

`ifndef SYNTHESIS
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with result pending");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp)) else $error("result changed");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
`endif

endmodule
